>>> hw/rtl/fcnl_pkg.sv
// Shared types and constants of the FAT cluster chain lookup block.
package fcnl_pkg;

  // File system type codes held in the fat_type register.
  localparam logic [1:0] FatType12 = 2'd0;
  localparam logic [1:0] FatType16 = 2'd1;
  localparam logic [1:0] FatType32 = 2'd2;

  // Command codes of an input transaction.
  localparam logic CmdLookup = 1'b0;
  localparam logic CmdData   = 1'b1;

  // Kind codes of a result transaction.
  localparam logic KindReadReq  = 1'b0;
  localparam logic KindNextNode = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;
  localparam logic [CfgIndexWidth-1:0] CfgFatType       = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgBytesPerSecLog2 = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgSecPerClusLog2  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgFirstDataSector = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgReservedSectors = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CfgFatSizeSectors  = 3'd5;

  // End-of-chain markers and entry masks.
  localparam logic [31:0] EocFat12  = 32'h0000_0FF8;
  localparam logic [31:0] EocFat16  = 32'h0000_FFF8;
  localparam logic [31:0] EocFat32  = 32'h0FFF_FFF8;
  localparam logic [31:0] MaskFat12 = 32'h0000_0FFF;
  localparam logic [31:0] MaskFat32 = 32'h0FFF_FFFF;

  // Legal range of the sector size exponent.
  localparam logic [3:0] SecLog2Min = 4'd9;
  localparam logic [3:0] SecLog2Max = 4'd12;

  typedef struct packed {
    logic        cmd;
    logic [31:0] current_sector;
    logic [1:0]  fat_copy;
    logic [31:0] entry_bytes;
    logic        read_failed;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] fat_sector;
    logic [11:0] byte_offset;
    logic        straddle;
    logic [31:0] next_node;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  fat_type;
    logic [3:0]  bytes_per_sector_log2;
    logic [2:0]  sectors_per_cluster_log2;
    logic [31:0] first_data_sector;
    logic [15:0] reserved_sectors;
    logic [31:0] fat_size_sectors;
  } cfg_t;

  typedef struct packed {
    logic lookup_pending;
    logic odd_cluster;
  } chain_state_t;

endpackage

>>> hw/rtl/fcnl_calc.sv
// Combinational lookup and entry extraction for one registered transaction.
module fcnl_calc (
  input  fcnl_pkg::cfg_t         cfg_i,
  input  fcnl_pkg::in_item_t     item_i,
  input  fcnl_pkg::chain_state_t state_i,
  output fcnl_pkg::chain_state_t state_o,
  output logic                   res_valid_o,
  output fcnl_pkg::out_item_t    res_o
);

  logic [31:0] eoc;
  logic [3:0]  sec_log2;
  logic [11:0] sec_mask;
  logic [31:0] cluster;
  logic [31:0] offset;
  logic [11:0] in_sec;
  logic [31:0] copy_base;
  logic [31:0] entry;
  logic [31:0] next_sector;

  always_comb begin
    case (cfg_i.fat_type)
      fcnl_pkg::FatType12: eoc = fcnl_pkg::EocFat12;
      fcnl_pkg::FatType16: eoc = fcnl_pkg::EocFat16;
      default:             eoc = fcnl_pkg::EocFat32;
    endcase
  end

  always_comb begin
    if (cfg_i.bytes_per_sector_log2 < fcnl_pkg::SecLog2Min) begin
      sec_log2 = fcnl_pkg::SecLog2Min;
    end else if (cfg_i.bytes_per_sector_log2 > fcnl_pkg::SecLog2Max) begin
      sec_log2 = fcnl_pkg::SecLog2Max;
    end else begin
      sec_log2 = cfg_i.bytes_per_sector_log2;
    end
  end

  // Low sec_log2 bits set; sec_log2 never exceeds the 12 offset bits.
  assign sec_mask = 12'((13'd1 << sec_log2) - 13'd1);

  assign cluster = ((item_i.current_sector - cfg_i.first_data_sector)
                    >> cfg_i.sectors_per_cluster_log2) + 32'd2;

  always_comb begin
    case (cfg_i.fat_type)
      fcnl_pkg::FatType12: offset = cluster + (cluster >> 1);
      fcnl_pkg::FatType16: offset = cluster << 1;
      default:             offset = cluster << 2;
    endcase
  end

  assign in_sec = offset[11:0] & sec_mask;

  // The copy index is two bits, so its product is two gated addends.
  assign copy_base = (cfg_i.fat_size_sectors & {32{item_i.fat_copy[0]}})
                   + ((cfg_i.fat_size_sectors << 1) & {32{item_i.fat_copy[1]}});

  // FAT12 odd clusters sit in the upper 12 bits of the byte pair.
  always_comb begin
    case (cfg_i.fat_type)
      fcnl_pkg::FatType12: begin
        if (state_i.odd_cluster) begin
          entry = {20'd0, item_i.entry_bytes[15:4]};
        end else begin
          entry = {20'd0, item_i.entry_bytes[11:0]};
        end
      end
      fcnl_pkg::FatType16: entry = {16'd0, item_i.entry_bytes[15:0]};
      default:             entry = item_i.entry_bytes & fcnl_pkg::MaskFat32;
    endcase
  end

  assign next_sector = ((entry - 32'd2) << cfg_i.sectors_per_cluster_log2)
                     + cfg_i.first_data_sector;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_i.cmd == fcnl_pkg::CmdLookup) begin
      res_valid_o = 1'b1;
      if (item_i.current_sector == eoc) begin
        state_o.lookup_pending = 1'b0;
        res_o.kind             = fcnl_pkg::KindNextNode;
        res_o.next_node        = eoc;
      end else begin
        state_o.lookup_pending = 1'b1;
        state_o.odd_cluster    = cluster[0];
        res_o.kind             = fcnl_pkg::KindReadReq;
        res_o.fat_sector       = {16'd0, cfg_i.reserved_sectors}
                               + (offset >> sec_log2) + copy_base;
        res_o.byte_offset      = in_sec;
        res_o.straddle         = (cfg_i.fat_type == fcnl_pkg::FatType12)
                                 && (in_sec == sec_mask);
      end
    end else if (state_i.lookup_pending) begin
      res_valid_o            = 1'b1;
      state_o.lookup_pending = 1'b0;
      res_o.kind             = fcnl_pkg::KindNextNode;
      res_o.next_node        = item_i.read_failed ? eoc : next_sector;
    end
  end

endmodule

>>> hw/rtl/fat_chain_next_lookup_top.sv
// Top level of the FAT cluster chain lookup block.
// The block takes one input transaction per clock cycle: a transaction is
// captured in an input register, the lookup or the entry extraction runs
// through one level of combinational logic, and the answer lands in the
// result register where it waits for the consumer. The sustained rate of
// one transaction per cycle holds as long as the consumer takes results.
// While the consumer stalls, one transaction waits in the result register
// and the next one in the input register; from then on in_ready_o follows
// out_ready_i in the same cycle.
// A lookup transaction (cmd 0) always yields one result: a read request for
// the FAT sector, byte offset and straddle flag, or the end-of-chain marker
// at once when the given sector is that marker. A data transaction (cmd 1)
// yields the next node as a data sector, or the marker if the read failed;
// with no lookup pending it is consumed silently. A new lookup replaces a
// pending one. Configuration registers are written through the plain write
// port and must only be changed while no transaction is in flight.
module fat_chain_next_lookup_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fcnl_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [fcnl_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  fcnl_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output fcnl_pkg::out_item_t                  out_item_o
);

  fcnl_pkg::cfg_t         cfg_q;
  fcnl_pkg::chain_state_t state_q;
  fcnl_pkg::chain_state_t state_d;
  logic                   s1_valid_q;
  fcnl_pkg::in_item_t     s1_item_q;
  logic                   out_valid_q;
  fcnl_pkg::out_item_t    out_item_q;
  logic                   res_valid;
  fcnl_pkg::out_item_t    res;
  logic                   s1_advance;

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fat_type                 <= fcnl_pkg::FatType12;
      cfg_q.bytes_per_sector_log2    <= fcnl_pkg::SecLog2Min;
      cfg_q.sectors_per_cluster_log2 <= 3'd0;
      cfg_q.first_data_sector        <= 32'd0;
      cfg_q.reserved_sectors         <= 16'd1;
      cfg_q.fat_size_sectors         <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcnl_pkg::CfgFatType:         cfg_q.fat_type <= cfg_data_i[1:0];
        fcnl_pkg::CfgBytesPerSecLog2: cfg_q.bytes_per_sector_log2 <= cfg_data_i[3:0];
        fcnl_pkg::CfgSecPerClusLog2:  cfg_q.sectors_per_cluster_log2 <= cfg_data_i[2:0];
        fcnl_pkg::CfgFirstDataSector: cfg_q.first_data_sector <= cfg_data_i;
        fcnl_pkg::CfgReservedSectors: cfg_q.reserved_sectors <= cfg_data_i[15:0];
        fcnl_pkg::CfgFatSizeSectors:  cfg_q.fat_size_sectors <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The input register moves on when the result register is free or is
  // being emptied in this cycle. A data transaction with nothing pending
  // moves on as well, without producing a result.
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;

  fcnl_calc u_calc (
    .cfg_i       (cfg_q),
    .item_i      (s1_item_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        out_valid_q <= res_valid;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (s1_advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
